/* hdl/ccpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ccpf_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_IDX_W   = $clog2(CORDIC_STAGES);

    // Datapath widths for the CORDIC vector and angle.
    localparam int XY_W = 40;
    localparam int Z_W  = 34;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    localparam logic signed [24:0] INV_GAIN_Q24   = 25'sd10187982;
    localparam logic signed [18:0] PI_Q16         = 19'sd205887;
    localparam logic signed [26:0] HEAD_TO_BAM_Q8 = 27'sd42722829;

    localparam logic signed [17:0] TURN_MAX = 18'sd131071;
    localparam logic signed [17:0] TURN_MIN = -18'sd131072;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_X       = 3'd0;
    localparam logic [2:0] CFG_START_Y       = 3'd1;
    localparam logic [2:0] CFG_GOAL_X        = 3'd2;
    localparam logic [2:0] CFG_GOAL_Y        = 3'd3;
    localparam logic [2:0] CFG_STEER_GAIN    = 3'd4;
    localparam logic [2:0] CFG_LOOKAHEAD     = 3'd5;
    localparam logic [2:0] CFG_CRUISE_SPEED  = 3'd6;
    localparam logic [2:0] CFG_ARRIVE_RADIUS = 3'd7;

    // Configuration reset values.
    localparam logic signed [31:0] RST_START_X       = 32'sd262144;
    localparam logic signed [31:0] RST_START_Y       = 32'sd98304;
    localparam logic signed [31:0] RST_GOAL_X        = -32'sd196608;
    localparam logic signed [31:0] RST_GOAL_Y        = 32'sd98304;
    localparam logic [15:0]        RST_STEER_GAIN    = 16'd2048;
    localparam logic [30:0]        RST_LOOKAHEAD     = 31'd32768;
    localparam logic [19:0]        RST_CRUISE_SPEED  = 20'd13107;
    localparam logic [19:0]        RST_ARRIVE_RADIUS = 20'd6554;

    // Arctangent of 2^-i in binary-angle units (2^32 is one turn).
    localparam logic [31:0] ATAN_BAM [32] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    typedef enum logic {
        MODE_VECTOR,
        MODE_ROTATE
    } cord_mode_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cord_t;

    typedef struct packed {
        logic signed [XY_W-1:0] a;
        logic signed [XY_W-1:0] b;
        logic [31:0]            theta;
        logic signed [15:0]     head;
        logic                   arrived;
        logic                   zero;
    } side_t;

endpackage

`default_nettype wire

/* hdl/ccpf_pose_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ccpf_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] heading;

    modport source (output valid, output pose_x, output pose_y, output heading, input ready);
    modport sink (input valid, input pose_x, input pose_y, input heading, output ready);
endinterface

`default_nettype wire

/* hdl/ccpf_cmd_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ccpf_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] turn_rate;
    logic [19:0]        forward_speed;
    logic               reached;

    modport source (output valid, output turn_rate, output forward_speed, output reached,
                    input ready);
    modport sink (input valid, input turn_rate, input forward_speed, input reached,
                  output ready);
endinterface

`default_nettype wire

/* hdl/ccpf_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ccpf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/ccpf_cordic_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One CORDIC micro-rotation with its own pipeline register and handshake.
module ccpf_cordic_cell
    import ccpf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cord_mode_t             mode,
    input  wire logic [STAGE_IDX_W-1:0] idx,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire cord_t                  in_cord,
    input  wire side_t                  in_side,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output cord_t                       out_cord,
    output side_t                       out_side
);

    logic                   valid_reg;
    cord_t                  cord_reg;
    cord_t                  cord_next;
    side_t                  side_reg;
    logic                   en;
    logic                   dir;
    logic signed [XY_W-1:0] shx;
    logic signed [XY_W-1:0] shy;
    logic signed [Z_W-1:0]  at;

    always_comb
    begin
        shx = in_cord.x >>> idx;
        shy = in_cord.y >>> idx;
        at  = Z_W'(signed'({1'b0, ATAN_BAM[5'(idx)]}));
        // Vectoring drives y toward zero, rotation drives z toward zero.
        dir = (mode == MODE_VECTOR) ? in_cord.y[XY_W-1] : !in_cord.z[Z_W-1];
        if (dir)
        begin
            cord_next.x = in_cord.x - shy;
            cord_next.y = in_cord.y + shx;
            cord_next.z = in_cord.z - at;
        end
        else
        begin
            cord_next.x = in_cord.x + shy;
            cord_next.y = in_cord.y - shx;
            cord_next.z = in_cord.z + at;
        end
    end

    assign en        = !valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg;
    assign out_cord  = cord_reg;
    assign out_side  = side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            cord_reg <= cord_next;
            side_reg <= in_side;
        end
    end

endmodule

`default_nettype wire

/* hdl/carrot_chase_path_follower_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Carrot-chasing steering for one straight segment. Each pose beat on the
// pose channel yields exactly one command beat, in order. A pose strictly
// inside the arrival radius of the goal gives zero turn rate, zero speed and
// reached set. Otherwise the pose is projected onto the start-to-goal line, a
// carrot is placed at |a| + lookahead along it, and the command is steer_gain
// times the wrapped heading error to the carrot, saturated, with cruise_speed.
// The datapath is a pipeline of 3*CORDIC_STAGES+7 registers built from three
// rows of CORDIC cells: one finds the line direction, one rotates the pose
// into the line frame, one finds the direction to the carrot. A new pose is
// accepted every cycle unless a full pipeline waits on the command channel;
// throughput is one beat per clock, set by the fully pipelined cell rows. Each
// register stage has its own valid bit, so bubbles collapse and poses keep
// entering while a finished command waits on the command channel. Configuration
// writes are always accepted and must be issued only while the block is idle.
module carrot_chase_path_follower_unit
    import ccpf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ccpf_pose_if.sink  pose,
    ccpf_cmd_if.source cmd,
    ccpf_cfg_if.sink   cfg
);

    localparam int N = CORDIC_STAGES;

    // Configuration registers.
    logic signed [31:0] start_x_reg;
    logic signed [31:0] start_y_reg;
    logic signed [31:0] goal_x_reg;
    logic signed [31:0] goal_y_reg;
    logic [15:0]        steer_gain_reg;
    logic [30:0]        lookahead_reg;
    logic [19:0]        cruise_speed_reg;
    logic [19:0]        arrive_radius_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg       <= RST_START_X;
            start_y_reg       <= RST_START_Y;
            goal_x_reg        <= RST_GOAL_X;
            goal_y_reg        <= RST_GOAL_Y;
            steer_gain_reg    <= RST_STEER_GAIN;
            lookahead_reg     <= RST_LOOKAHEAD;
            cruise_speed_reg  <= RST_CRUISE_SPEED;
            arrive_radius_reg <= RST_ARRIVE_RADIUS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_START_X:       start_x_reg       <= cfg.data;
                CFG_START_Y:       start_y_reg       <= cfg.data;
                CFG_GOAL_X:        goal_x_reg        <= cfg.data;
                CFG_GOAL_Y:        goal_y_reg        <= cfg.data;
                CFG_STEER_GAIN:    steer_gain_reg    <= cfg.data[15:0];
                CFG_LOOKAHEAD:     lookahead_reg     <= cfg.data[30:0];
                CFG_CRUISE_SPEED:  cruise_speed_reg  <= cfg.data[19:0];
                CFG_ARRIVE_RADIUS: arrive_radius_reg <= cfg.data[19:0];
                default:           ;
            endcase
        end
    end

    // Handshake chain. Each stage loads when it is empty or its successor loads.
    logic v_s0_reg, v_r0_reg, v_m_reg, v_c0_reg, v_e1_reg, v_e2_reg, v_e3_reg;
    logic en_s0, en_r0, en_m, en_c0, en_e1, en_e2, en_e3;

    logic  a_v   [N+1];
    logic  a_rdy [N+1];
    cord_t a_cord[N+1];
    side_t a_side[N+1];
    logic  b_v   [N+1];
    logic  b_rdy [N+1];
    cord_t b_cord[N+1];
    side_t b_side[N+1];
    logic  c_v   [N+1];
    logic  c_rdy [N+1];
    cord_t c_cord[N+1];
    side_t c_side[N+1];

    assign en_e3 = !v_e3_reg || cmd.ready;
    assign en_e2 = !v_e2_reg || en_e3;
    assign en_e1 = !v_e1_reg || en_e2;
    assign en_c0 = !v_c0_reg || c_rdy[0];
    assign en_m  = !v_m_reg  || en_c0;
    assign en_r0 = !v_r0_reg || b_rdy[0];
    assign en_s0 = !v_s0_reg || a_rdy[0];

    assign pose.ready = en_s0;
    assign a_rdy[N]   = en_r0;
    assign b_rdy[N]   = en_m;
    assign c_rdy[N]   = en_e1;

    // Entry stage: arrival test, pose offset from start, and the first
    // vectoring setup for the start-to-goal direction.
    cord_t              s0_cord_reg, s0_cord_next;
    side_t              s0_side_reg, s0_side_next;
    logic signed [32:0] dgx, dgy, vx, vy;
    logic signed [21:0] dxs, dys;
    logic signed [43:0] sqx, sqy;
    logic [42:0]        d2;
    logic [39:0]        r2;
    logic               near;

    always_comb
    begin
        dgx  = 33'(pose.pose_x) - 33'(goal_x_reg);
        dgy  = 33'(pose.pose_y) - 33'(goal_y_reg);
        near = (dgx > -33'sd2097152) && (dgx < 33'sd2097152) &&
               (dgy > -33'sd2097152) && (dgy < 33'sd2097152);
        dxs  = signed'(dgx[21:0]);
        dys  = signed'(dgy[21:0]);
        sqx  = dxs * dxs;
        sqy  = dys * dys;
        d2   = sqx[42:0] + sqy[42:0];
        r2   = 40'(arrive_radius_reg) * 40'(arrive_radius_reg);

        vx = 33'(goal_x_reg) - 33'(start_x_reg);
        vy = 33'(goal_y_reg) - 33'(start_y_reg);

        s0_side_next.a       = XY_W'(33'(pose.pose_x) - 33'(start_x_reg));
        s0_side_next.b       = XY_W'(33'(pose.pose_y) - 33'(start_y_reg));
        s0_side_next.theta   = '0;
        s0_side_next.head    = pose.heading;
        s0_side_next.arrived = near && (d2 < {3'b000, r2});
        s0_side_next.zero    = (vx == '0) && (vy == '0);

        // A vector in the left half-plane is turned by half a turn first.
        if (vx[32])
        begin
            s0_cord_next.x = -XY_W'(vx);
            s0_cord_next.y = -XY_W'(vy);
            s0_cord_next.z = Z_W'({1'b0, HALF_TURN});
        end
        else
        begin
            s0_cord_next.x = XY_W'(vx);
            s0_cord_next.y = XY_W'(vy);
            s0_cord_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s0_reg <= 1'b0;
            v_r0_reg <= 1'b0;
            v_m_reg  <= 1'b0;
            v_c0_reg <= 1'b0;
            v_e1_reg <= 1'b0;
            v_e2_reg <= 1'b0;
            v_e3_reg <= 1'b0;
        end
        else
        begin
            if (en_s0) v_s0_reg <= pose.valid;
            if (en_r0) v_r0_reg <= a_v[N];
            if (en_m)  v_m_reg  <= b_v[N];
            if (en_c0) v_c0_reg <= v_m_reg;
            if (en_e1) v_e1_reg <= c_v[N];
            if (en_e2) v_e2_reg <= v_e1_reg;
            if (en_e3) v_e3_reg <= v_e2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s0 && pose.valid)
        begin
            s0_cord_reg <= s0_cord_next;
            s0_side_reg <= s0_side_next;
        end
    end

    assign a_v[0]    = v_s0_reg;
    assign a_cord[0] = s0_cord_reg;
    assign a_side[0] = s0_side_reg;

    // Row A: vectoring cells give the line direction theta.
    for (genvar k = 0; k < N; k++)
    begin : g_row_a
        ccpf_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .mode      (MODE_VECTOR),
            .idx       (STAGE_IDX_W'(k)),
            .in_valid  (a_v[k]),
            .in_ready  (a_rdy[k]),
            .in_cord   (a_cord[k]),
            .in_side   (a_side[k]),
            .out_valid (a_v[k+1]),
            .out_ready (a_rdy[k+1]),
            .out_cord  (a_cord[k+1]),
            .out_side  (a_side[k+1])
        );
    end

    // Rotation setup: turn the pose offset by minus theta. Angles beyond a
    // quarter turn are first folded by half a turn with the vector negated.
    cord_t              r0_cord_reg, r0_cord_next;
    side_t              r0_side_reg, r0_side_next;
    logic [31:0]        theta, nang, fang;
    logic signed [Z_W-1:0] zr, zf;
    logic               flip;

    always_comb
    begin
        theta = a_side[N].zero ? 32'd0 : a_cord[N].z[31:0];
        nang  = 32'd0 - theta;
        fang  = nang + HALF_TURN;
        zr    = Z_W'(signed'(nang));
        zf    = Z_W'(signed'(fang));
        flip  = (zr > Z_W'(33'sh0_4000_0000)) || (zr < -Z_W'(33'sh0_4000_0000));
        r0_side_next       = a_side[N];
        r0_side_next.theta = theta;
        r0_cord_next.x     = flip ? -a_side[N].a : a_side[N].a;
        r0_cord_next.y     = flip ? -a_side[N].b : a_side[N].b;
        r0_cord_next.z     = flip ? zf : zr;
    end

    always_ff @(posedge clk)
    begin
        if (en_r0 && a_v[N])
        begin
            r0_cord_reg <= r0_cord_next;
            r0_side_reg <= r0_side_next;
        end
    end

    assign b_v[0]    = v_r0_reg;
    assign b_cord[0] = r0_cord_reg;
    assign b_side[0] = r0_side_reg;

    // Row B: rotation cells bring the pose into the line frame.
    for (genvar k = 0; k < N; k++)
    begin : g_row_b
        ccpf_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .mode      (MODE_ROTATE),
            .idx       (STAGE_IDX_W'(k)),
            .in_valid  (b_v[k]),
            .in_ready  (b_rdy[k]),
            .in_cord   (b_cord[k]),
            .in_side   (b_side[k]),
            .out_valid (b_v[k+1]),
            .out_ready (b_rdy[k+1]),
            .out_cord  (b_cord[k+1]),
            .out_side  (b_side[k+1])
        );
    end

    // Gain removal: along-track a and cross-track b, scaled by 1/K.
    side_t                  m_side_reg, m_side_next;
    logic signed [XY_W+24:0] pa, pb;

    always_comb
    begin
        pa            = b_cord[N].x * INV_GAIN_Q24;
        pb            = b_cord[N].y * INV_GAIN_Q24;
        m_side_next   = b_side[N];
        m_side_next.a = pa[XY_W+23:24];
        m_side_next.b = pb[XY_W+23:24];
    end

    always_ff @(posedge clk)
    begin
        if (en_m && b_v[N])
        begin
            m_side_reg <= m_side_next;
        end
    end

    // Carrot vector in the line frame: (|a| + lookahead - a, -b).
    cord_t                  c0_cord_reg, c0_cord_next;
    side_t                  c0_side_reg, c0_side_next;
    logic signed [XY_W-1:0] abs_a, cx, cy;

    always_comb
    begin
        abs_a = m_side_reg.a[XY_W-1] ? -m_side_reg.a : m_side_reg.a;
        cx    = abs_a + XY_W'(signed'({1'b0, lookahead_reg})) - m_side_reg.a;
        cy    = -m_side_reg.b;
        c0_side_next      = m_side_reg;
        c0_side_next.zero = (cx == '0) && (cy == '0);
        if (cx[XY_W-1])
        begin
            c0_cord_next.x = -cx;
            c0_cord_next.y = -cy;
            c0_cord_next.z = Z_W'({1'b0, HALF_TURN});
        end
        else
        begin
            c0_cord_next.x = cx;
            c0_cord_next.y = cy;
            c0_cord_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c0 && v_m_reg)
        begin
            c0_cord_reg <= c0_cord_next;
            c0_side_reg <= c0_side_next;
        end
    end

    assign c_v[0]    = v_c0_reg;
    assign c_cord[0] = c0_cord_reg;
    assign c_side[0] = c0_side_reg;

    // Row C: vectoring cells give the carrot direction relative to the line.
    for (genvar k = 0; k < N; k++)
    begin : g_row_c
        ccpf_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .mode      (MODE_VECTOR),
            .idx       (STAGE_IDX_W'(k)),
            .in_valid  (c_v[k]),
            .in_ready  (c_rdy[k]),
            .in_cord   (c_cord[k]),
            .in_side   (c_side[k]),
            .out_valid (c_v[k+1]),
            .out_ready (c_rdy[k+1]),
            .out_cord  (c_cord[k+1]),
            .out_side  (c_side[k+1])
        );
    end

    // Target angle and heading in binary-angle units.
    logic [31:0]        e1_tgt_reg, e1_hb_reg;
    logic               e1_arr_reg;
    logic signed [42:0] hprod;
    logic [31:0]        tgt_next;

    always_comb
    begin
        tgt_next = c_side[N].theta + (c_side[N].zero ? 32'd0 : c_cord[N].z[31:0]);
        hprod    = c_side[N].head * HEAD_TO_BAM_Q8;
    end

    always_ff @(posedge clk)
    begin
        if (en_e1 && c_v[N])
        begin
            e1_tgt_reg <= tgt_next;
            e1_hb_reg  <= hprod[39:8];
            e1_arr_reg <= c_side[N].arrived;
        end
    end

    // Wrapped heading error converted to radians times 2^13.
    logic signed [16:0] e2_err13_reg;
    logic               e2_arr_reg;
    logic signed [31:0] err;
    logic signed [50:0] eprod;

    always_comb
    begin
        err   = signed'(e1_tgt_reg - e1_hb_reg);
        eprod = err * PI_Q16;
    end

    always_ff @(posedge clk)
    begin
        if (en_e2 && v_e1_reg)
        begin
            e2_err13_reg <= eprod[50:34];
            e2_arr_reg   <= e1_arr_reg;
        end
    end

    // Gain, saturation and the command register.
    logic signed [17:0] e3_turn_reg, turn_next;
    logic [19:0]        e3_speed_reg;
    logic               e3_reached_reg;
    logic signed [33:0] tprod;
    logic signed [21:0] tsh;

    always_comb
    begin
        tprod = e2_err13_reg * signed'({1'b0, steer_gain_reg});
        tsh   = tprod[33:12];
        if (tsh > 22'(TURN_MAX))
        begin
            turn_next = TURN_MAX;
        end
        else if (tsh < 22'(TURN_MIN))
        begin
            turn_next = TURN_MIN;
        end
        else
        begin
            turn_next = tsh[17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_e3 && v_e2_reg)
        begin
            e3_turn_reg    <= e2_arr_reg ? 18'sd0 : turn_next;
            e3_speed_reg   <= e2_arr_reg ? 20'd0 : cruise_speed_reg;
            e3_reached_reg <= e2_arr_reg;
        end
    end

    assign cmd.valid         = v_e3_reg;
    assign cmd.turn_rate     = e3_turn_reg;
    assign cmd.forward_speed = e3_speed_reg;
    assign cmd.reached       = e3_reached_reg;

endmodule

`default_nettype wire

/* hdl/ccpf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ccpf_checker
    import ccpf_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pose_ready,
    input wire logic               cmd_valid,
    input wire logic               cmd_ready,
    input wire logic signed [17:0] cmd_turn_rate,
    input wire logic [19:0]        cmd_forward_speed,
    input wire logic               cmd_reached,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready,
    input wire logic [2:0]         cfg_index,
    input wire logic [19:0]        cfg_data_low
);

    // Shadow of the cruise speed register, built from observed writes.
    logic [19:0] cruise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_reg <= RST_CRUISE_SPEED;
        end
        else if (cfg_valid && cfg_ready && (cfg_index == CFG_CRUISE_SPEED))
        begin
            cruise_reg <= cfg_data_low;
        end
    end

    // An arrival command stops the robot.
    a_reached_stops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_reached |-> (cmd_turn_rate == 18'sd0) && (cmd_forward_speed == 20'd0))
        else $error("arrival command is not a stop");

    // Outside the arrival radius the robot drives at the configured speed.
    a_cruise: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_reached |-> cmd_forward_speed == cruise_reg)
        else $error("forward speed differs from cruise speed");

    // With no command waiting the pipeline can always take a pose.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid |-> pose_ready)
        else $error("pose stalled while command side is empty");

    // A stalled command beat holds.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_turn_rate) &&
            $stable(cmd_forward_speed) && $stable(cmd_reached))
        else $error("stalled command beat changed");

endmodule

bind carrot_chase_path_follower_unit ccpf_checker u_ccpf_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .pose_ready        (pose.ready),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .cmd_turn_rate     (cmd.turn_rate),
    .cmd_forward_speed (cmd.forward_speed),
    .cmd_reached       (cmd.reached),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready),
    .cfg_index         (cfg.index),
    .cfg_data_low      (cfg.data[19:0])
);

`default_nettype wire
